// ===== sv/projected_structure_factor_unit_assert.svh =====
// Assertion macros for the projected structure factor unit checker.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef PROJECTED_STRUCTURE_FACTOR_UNIT_ASSERT_SVH
`define PROJECTED_STRUCTURE_FACTOR_UNIT_ASSERT_SVH

// antecedent in this cycle, consequent in the next
`define PSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psf assertion failed");

// antecedent and consequent in the same cycle
`define PSF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psf assertion failed");

`endif

// ===== sv/psf_pkg.sv =====
// Shared types, constants and the arctangent constants for the structure factor unit.
// No dependencies.
package psf_pkg;

	localparam int PHASE_BITS_DEF = 10;
	localparam int MAX_SIDE_DEF   = 256;
	localparam int CORDIC_STEPS   = 16;
	localparam int DIV_W          = 64;   // shared divider dividend width
	localparam int DVS_W          = 18;   // shared divider divisor width
	localparam int NUM_W          = 26;   // phase numerator and projection width
	localparam int MUL_W          = 33;   // shared multiplier operand width
	localparam int AMP_W          = 48;
	localparam int TOT_W          = 64;
	localparam int XY_W           = 34;   // CORDIC vector width
	localparam int Z_W            = 33;   // CORDIC angle width

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic signed [AMP_W:0]  AMP_LIMIT   = (AMP_W+1)'(48'h7FFF_FFFF_FFFF);
	localparam logic [TOT_W-1:0]       TOTAL_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

	// configuration register indexes
	localparam logic CFG_SIDE  = 1'b0;
	localparam logic CFG_TRANS = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_HX2, S_HY2, S_NX, S_NY, S_PA, S_PB, S_PC, S_DIV, S_COR,
		S_MC, S_MS, S_AI, S_CL, S_RE, S_IM, S_MAG, S_QDIV, S_FIN
	} state_t;

	// atan(2^-i) in turns scaled by 2^32
	function automatic logic [31:0] atan_turn(input logic [3:0] i);
		logic [31:0] v;
		case (i)
			4'd0:    v = 32'd536870912;
			4'd1:    v = 32'd316933406;
			4'd2:    v = 32'd167458907;
			4'd3:    v = 32'd85004756;
			4'd4:    v = 32'd42667330;
			4'd5:    v = 32'd21354465;
			4'd6:    v = 32'd10679839;
			4'd7:    v = 32'd5340245;
			4'd8:    v = 32'd2670163;
			4'd9:    v = 32'd1335087;
			4'd10:   v = 32'd667544;
			4'd11:   v = 32'd333772;
			4'd12:   v = 32'd166886;
			4'd13:   v = 32'd83443;
			4'd14:   v = 32'd41722;
			default: v = 32'd20861;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/psf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, shared for phase and close.
// Depends on psf_pkg.
module psf_div import psf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic             qbit;
	logic [DVS_W:0]   rem_sub;

	// one trial subtraction per cycle
	assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign qbit    = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

// ===== sv/psf_cordic.sv =====
// Iterative CORDIC giving Q1.15 cos and sin of a phase index, one rotation per cycle.
// Depends on psf_pkg.
module psf_cordic import psf_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PHASE_BITS-1:0] idx,
	output logic                  done,
	output logic signed [15:0]    cos_v,
	output logic signed [15:0]    sin_v
);
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [1:0]             quad_q;
	logic [3:0]             step_q;
	logic                   run_q, done_q;
	logic [31:0]            ang;
	logic signed [XY_W-1:0] xs, ys;
	logic signed [Z_W-1:0]  at;
	logic signed [XY_W-1:0] xr, yr;
	logic signed [18:0]     xq19, yq19;
	logic signed [16:0]     cq, sq, cm, sm;

	assign ang = {idx, (32 - PHASE_BITS)'(0)};
	assign xs  = x_q >>> step_q;
	assign ys  = y_q >>> step_q;
	assign at  = Z_W'(atan_turn(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 4'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// rotation registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= Z_W'(ang[29:0]);
			quad_q <= ang[31:30];
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// round half up to Q1.15, clamp, fold into the quadrant
	always_comb begin
		xr   = x_q + XY_W'(16384);
		yr   = y_q + XY_W'(16384);
		xq19 = 19'(xr >>> 15);
		yq19 = 19'(yr >>> 15);
		cq   = (xq19 > 19'sd32767) ? 17'sd32767 :
		       (xq19 < -19'sd32768) ? -17'sd32768 : 17'(xq19);
		sq   = (yq19 > 19'sd32767) ? 17'sd32767 :
		       (yq19 < -19'sd32768) ? -17'sd32768 : 17'(yq19);
		case (quad_q)
			2'd0:    begin cm = cq;  sm = sq;  end
			2'd1:    begin cm = -sq; sm = cq;  end
			2'd2:    begin cm = -cq; sm = -sq; end
			default: begin cm = sq;  sm = -cq; end
		endcase
		cos_v = (cm > 17'sd32767) ? 16'sd32767 : 16'(cm);
		sin_v = (sm > 17'sd32767) ? 16'sd32767 : 16'(sm);
	end

	assign done = done_q;
endmodule

// ===== sv/projected_structure_factor_unit.sv =====
// Top level of the projected structure factor unit: sequencer, shared multiplier,
// accumulators and output register. Depends on psf_pkg, psf_div and psf_cordic.
//
// Usage: items enter on in_valid/in_ready, one at a time; in_ready is high only
// while the sequencer is idle. An item with a non-zero wavevector passes, from one
// accepted beat to the next, through six multiplier steps, the phase division on the
// shared one-bit-per-cycle divider, the 16 CORDIC rotations, the accumulate and the
// idle state. An item with a zero wavevector skips the divider, CORDIC and accumulate.
// Closing a wavevector (last_particle or last_wave) adds the magnitude steps and a
// second pass through the divider; with a zero wavevector it adds only the final state.
// A last_wave beat yields one result on out_valid/out_ready, held in an output
// register; the next item may be accepted while that result waits. If a new
// result is ready while the old one is still stalled, the sequencer waits.
// Configuration writes on cfg_valid/cfg_ready are always taken, one per cycle.
// Reset clears the accumulators, the total, the saturation flag and out_valid,
// and sets side_length to 16 and the projection to longitudinal.
module projected_structure_factor_unit import psf_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF,
	parameter int MAX_SIDE   = MAX_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [8:0]  wave_x,
	input  logic signed [8:0]  wave_y,
	input  logic signed [15:0] eigen_x,
	input  logic signed [15:0] eigen_y,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic               last_particle,
	input  logic               last_wave,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [62:0]        intensity,
	output logic               saturated
);
	state_t state_q, state_d;

	logic [8:0]               side_q;
	logic                     trans_q;
	logic signed [8:0]        hx_q, hy_q;
	logic signed [15:0]       ex_q, ey_q, px_q, py_q;
	logic                     lp_q, lw_q;
	logic [DVS_W-1:0]         hh_q;
	logic signed [NUM_W-1:0]  num_q, p_q;
	logic signed [2*MUL_W-1:0] prod_q;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [AMP_W-1:0]  amp_re_q, amp_im_q;
	logic [TOT_W-1:0]         total_q, mag_q;
	logic                     ovf_q;
	logic                     out_valid_q, sat_out_q;
	logic [62:0]              int_out_q;

	logic                     div_start, div_done, cor_start, cor_done;
	logic [DIV_W-1:0]         div_dvd, div_quot;
	logic [DVS_W-1:0]         div_dvs, side_c, d_val;
	logic signed [15:0]       cos_v, sin_v;
	logic signed [15:0]       cos_q, sin_q;
	logic signed [31:0]       re_top, im_top;
	logic signed [AMP_W:0]    acc_sum;
	logic signed [AMP_W-1:0]  acc_res;
	logic                     acc_sat;
	logic [DIV_W-1:0]         phase_a;
	logic [TOT_W-1:0]         room;
	logic                     close_now, emit_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign intensity = int_out_q;
	assign saturated = sat_out_q;

	assign re_top    = amp_re_q[AMP_W-1:16];
	assign im_top    = amp_im_q[AMP_W-1:16];
	assign close_now = lp_q | lw_q;
	assign emit_ok   = !out_valid_q || out_ready;

	// clamped side length and phase divisor 64*side
	always_comb begin
		if (side_q == 9'd0)
			side_c = DVS_W'(1);
		else if (32'(side_q) > MAX_SIDE)
			side_c = DVS_W'(MAX_SIDE);
		else
			side_c = DVS_W'(side_q);
		d_val = side_c << 6;
	end

	// numerator made non-negative by adding side<<25, a multiple of the divisor
	assign phase_a = (DIV_W'(num_q) + (DIV_W'(side_c) << 25)) << PHASE_BITS;

	// shared saturating accumulate, real in S_MS, imaginary in S_AI
	always_comb begin
		acc_sum = (state_q == S_MS) ? (AMP_W+1)'(amp_re_q) : (AMP_W+1)'(amp_im_q);
		acc_sum = acc_sum + (AMP_W+1)'(signed'(prod_q[41:0]));
		acc_sat = 1'b0;
		if (acc_sum > AMP_LIMIT) begin
			acc_res = AMP_W'(AMP_LIMIT);
			acc_sat = 1'b1;
		end else if (acc_sum < -AMP_LIMIT) begin
			acc_res = AMP_W'(-AMP_LIMIT);
			acc_sat = 1'b1;
		end else begin
			acc_res = AMP_W'(acc_sum);
		end
	end

	assign room = TOTAL_LIMIT - total_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_HX2;
			S_HX2:  state_d = S_HY2;
			S_HY2:  state_d = S_NX;
			S_NX:   state_d = S_NY;
			S_NY:   state_d = S_PA;
			S_PA:   state_d = S_PB;
			S_PB:   state_d = S_PC;
			S_PC:   state_d = (hh_q == '0) ? S_CL : S_DIV;
			S_DIV:  if (div_done) state_d = S_COR;
			S_COR:  if (cor_done) state_d = S_MC;
			S_MC:   state_d = S_MS;
			S_MS:   state_d = S_AI;
			S_AI:   state_d = S_CL;
			S_CL: begin
				if (!close_now)
					state_d = S_IDLE;
				else if (hh_q == '0)
					state_d = S_FIN;
				else
					state_d = S_RE;
			end
			S_RE:   state_d = S_IM;
			S_IM:   state_d = S_MAG;
			S_MAG:  state_d = S_QDIV;
			S_QDIV: if (div_done) state_d = S_FIN;
			S_FIN:  if (!lw_q || emit_ok) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// multiplier operands and unit starts
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = phase_a;
		div_dvs   = d_val;
		cor_start = 1'b0;
		case (state_q)
			S_HX2: begin mul_a = MUL_W'(hx_q); mul_b = MUL_W'(hx_q); end
			S_HY2: begin mul_a = MUL_W'(hy_q); mul_b = MUL_W'(hy_q); end
			S_NX:  begin mul_a = MUL_W'(hx_q); mul_b = MUL_W'(px_q); end
			S_NY:  begin mul_a = MUL_W'(hy_q); mul_b = MUL_W'(py_q); end
			S_PA: begin
				mul_a = MUL_W'(ex_q);
				mul_b = trans_q ? MUL_W'(hy_q) : MUL_W'(hx_q);
			end
			S_PB: begin
				mul_a     = MUL_W'(ey_q);
				mul_b     = trans_q ? MUL_W'(hx_q) : MUL_W'(hy_q);
				div_start = (hh_q != '0);
			end
			S_DIV: cor_start = div_done;
			S_MC:  begin mul_a = MUL_W'(p_q); mul_b = MUL_W'(cos_q); end
			S_MS:  begin mul_a = MUL_W'(p_q); mul_b = MUL_W'(sin_q); end
			S_RE:  begin mul_a = MUL_W'(re_top); mul_b = MUL_W'(re_top); end
			S_IM:  begin mul_a = MUL_W'(im_top); mul_b = MUL_W'(im_top); end
			S_MAG: begin
				div_start = 1'b1;
				div_dvd   = mag_q + prod_q[TOT_W-1:0];
				div_dvs   = hh_q;
			end
			default: ;
		endcase
	end

	// control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			side_q      <= 9'd16;
			trans_q     <= 1'b0;
			amp_re_q    <= '0;
			amp_im_q    <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SIDE:  side_q  <= cfg_data;
					CFG_TRANS: trans_q <= cfg_data[0];
					default:   ;
				endcase
			end
			// result beat: a new one replaces the one taken in the same cycle
			if (state_q == S_FIN && lw_q && emit_ok)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_MS: begin
					amp_re_q <= acc_res;
					if (acc_sat) ovf_q <= 1'b1;
				end
				S_AI: begin
					amp_im_q <= acc_res;
					if (acc_sat) ovf_q <= 1'b1;
				end
				S_QDIV: begin
					if (div_done) begin
						if (div_quot > room) begin
							total_q <= TOTAL_LIMIT;
							ovf_q   <= 1'b1;
						end else begin
							total_q <= total_q + div_quot;
						end
					end
				end
				S_FIN: begin
					amp_re_q <= '0;
					amp_im_q <= '0;
					if (lw_q && emit_ok) begin
						total_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// item payload, shared product and intermediate values
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_IDLE && in_valid) begin
			hx_q <= wave_x;
			hy_q <= wave_y;
			ex_q <= eigen_x;
			ey_q <= eigen_y;
			px_q <= pos_x;
			py_q <= pos_y;
			lp_q <= last_particle;
			lw_q <= last_wave;
		end
		case (state_q)
			S_HY2: hh_q  <= DVS_W'(prod_q);
			S_NX:  hh_q  <= hh_q + DVS_W'(prod_q);
			S_NY:  num_q <= NUM_W'(prod_q);
			S_PA:  num_q <= num_q + NUM_W'(prod_q);
			S_PB:  p_q   <= NUM_W'(prod_q);
			S_PC:  p_q   <= trans_q ? p_q - NUM_W'(prod_q) : p_q + NUM_W'(prod_q);
			S_IM:  mag_q <= prod_q[TOT_W-1:0];
			default: ;
		endcase
		if (cor_done) begin
			cos_q <= cos_v;
			sin_q <= sin_v;
		end
		if (state_q == S_FIN && lw_q && emit_ok) begin
			int_out_q <= total_q[62:0];
			sat_out_q <= ovf_q;
		end
	end

	psf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quot)
	);

	psf_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.idx    (div_quot[PHASE_BITS-1:0]),
		.done   (cor_done),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);
endmodule

// ===== sv/psf_checker.sv =====
// Port-level checker for the structure factor unit, bound to the top level.
// Depends on projected_structure_factor_unit_assert.svh.
`include "projected_structure_factor_unit_assert.svh"

module psf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [62:0] intensity,
	input logic        saturated
);
	// a taken beat makes the sequencer busy
	`PSF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// a result appears only as the sequencer finishes an item
	`PSF_ASSERT_SAME(a_result_from_busy, $rose(out_valid), !$past(in_ready))
	// a stalled result holds
	`PSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(intensity) && $stable(saturated))
endmodule

bind projected_structure_factor_unit psf_checker u_psf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.intensity (intensity),
	.saturated (saturated)
);

// ===== verif/tb_projected_structure_factor_unit.sv =====
// Self-checking bench for projected_structure_factor_unit: directed and random wavevector
// sets are checked against a built-in fixed-point structure factor predictor.
// Depends on psf_pkg and the RTL of the unit.
module tb_projected_structure_factor_unit;
	import psf_pkg::*;

	typedef struct packed {
		logic [62:0] intensity;
		logic        saturated;
	} sf_result_t;

	localparam longint AMP_MAX   = 64'sh7FFF_FFFF_FFFF;
	localparam longint unsigned TOT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int     SETTLE    = 400;
	localparam longint CYCLE_CAP = 3000000;

	// arctangent of 2^-i in turns scaled by 2^32
	localparam longint ROT_ANGLE [16] = '{
		536870912, 316933406, 167458907, 85004756, 42667330, 21354465,
		10679839, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861};

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [8:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [8:0]  wave_x;
	logic signed [8:0]  wave_y;
	logic signed [15:0] eigen_x;
	logic signed [15:0] eigen_y;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic               last_particle;
	logic               last_wave;
	logic               out_valid;
	logic               out_ready;
	logic [62:0]        intensity;
	logic               saturated;

	projected_structure_factor_unit dut (.*);

	// predictor state
	logic [8:0]          pred_side;
	logic                pred_trans;
	longint              pred_re;
	longint              pred_im;
	longint unsigned     pred_total;
	logic                pred_ovf;
	sf_result_t          pending_totals[$];

	int     mismatches;
	int     idle_pct;
	int     stall_pct;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// runaway guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic longint q15_round(input longint v);
		longint r;
		r = (v + (64'sd1 <<< 14)) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	// cos and sin in Q1.15 for a phase index
	task automatic phase_trig(input longint idx, output longint c, output longint s);
		logic [31:0] ang;
		longint x, y, z, xs, ys, cq, sq;
		ang = 32'(idx << (32 - PHASE_BITS_DEF));
		x = 652032874;
		y = 0;
		z = longint'(ang[29:0]);
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ROT_ANGLE[i];
			end else begin
				x += ys; y -= xs; z += ROT_ANGLE[i];
			end
		end
		cq = q15_round(x);
		sq = q15_round(y);
		case (ang[31:30])
			2'd0: begin c = cq; s = sq; end
			2'd1: begin c = -sq; s = cq; end
			2'd2: begin c = -cq; s = -sq; end
			default: begin c = sq; s = -cq; end
		endcase
		if (c > 32767) c = 32767;
		if (s > 32767) s = 32767;
	endtask

	function automatic longint amp_sat_add(input longint a, input longint b, inout logic ovf);
		longint r;
		r = a + b;
		if (r > AMP_MAX) begin r = AMP_MAX; ovf = 1'b1; end
		if (r < -AMP_MAX) begin r = -AMP_MAX; ovf = 1'b1; end
		return r;
	endfunction

	// fold one accepted particle beat into the predicted amplitudes and total
	task automatic absorb_particle();
		longint hx, hy, ex, ey, px, py, hh, d, num, r, idx, c, s, p, re, im;
		longint unsigned side, mag, q;
		sf_result_t res;
		hx = wave_x; hy = wave_y; ex = eigen_x; ey = eigen_y; px = pos_x; py = pos_y;
		hh = hx * hx + hy * hy;
		if (hh != 0) begin
			side = pred_side;
			if (side == 0) side = 1;
			if (side > MAX_SIDE_DEF) side = MAX_SIDE_DEF;
			d = 64 * longint'(side);
			num = hx * px + hy * py;
			r = num % d;
			if (r < 0) r += d;
			idx = (r << PHASE_BITS_DEF) / d;
			phase_trig(idx, c, s);
			p = pred_trans ? (ex * hy - ey * hx) : (ex * hx + ey * hy);
			pred_re = amp_sat_add(pred_re, p * c, pred_ovf);
			pred_im = amp_sat_add(pred_im, p * s, pred_ovf);
		end
		if (last_particle || last_wave) begin
			if (hh != 0) begin
				re = pred_re >>> 16;
				im = pred_im >>> 16;
				mag = longint'(re * re) + longint'(im * im);
				q = mag / longint'(hh);
				if (q > TOT_MAX - pred_total) begin
					pred_total = TOT_MAX;
					pred_ovf = 1'b1;
				end else begin
					pred_total += q;
				end
			end
			pred_re = 0;
			pred_im = 0;
		end
		if (last_wave) begin
			res.intensity = pred_total[62:0];
			res.saturated = pred_ovf;
			pending_totals = {pending_totals, res};
			pred_total = 0;
			pred_ovf = 1'b0;
		end
	endtask

	// beat monitor: config, input and result channels
	always @(posedge clk) begin
		sf_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SIDE) pred_side = cfg_data;
				else pred_trans = cfg_data[0];
			end
			if (in_valid && in_ready) absorb_particle();
			if (out_valid && out_ready) begin
				if (pending_totals.size() == 0) begin
					$error("unexpected result beat intensity=%0d", intensity);
					mismatches++;
				end else begin
					want = pending_totals.pop_front();
					if (intensity !== want.intensity) begin
						$error("intensity expected %0d got %0d", want.intensity, intensity);
						mismatches++;
					end
					if (saturated !== want.saturated) begin
						$error("saturated expected %0d got %0d", want.saturated, saturated);
						mismatches++;
					end
				end
			end
		end
	end

	// one particle beat; called at a falling edge, returns at a falling edge
	task automatic send_particle(input logic signed [8:0] hx, input logic signed [8:0] hy,
			input logic signed [15:0] ex, input logic signed [15:0] ey,
			input logic signed [15:0] px, input logic signed [15:0] py,
			input logic lp, input logic lw);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		wave_x <= hx; wave_y <= hy; eigen_x <= ex; eigen_y <= ey;
		pos_x <= px; pos_y <= py; last_particle <= lp; last_wave <= lw;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	// wait until the unit is quiet, then write a register; called at a falling edge
	task automatic write_reg(input logic idx, input logic [8:0] val);
		in_valid <= 1'b0;
		while (pending_totals.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand16();
		return 16'($urandom);
	endfunction

	// one well-formed set of wavevectors with random content
	task automatic send_random_set(input int max_waves, input int max_parts);
		int nw, np;
		logic signed [8:0] hx, hy;
		nw = $urandom_range(max_waves, 1);
		for (int w = 0; w < nw; w++) begin
			np = $urandom_range(max_parts, 1);
			hx = ($urandom_range(9) == 0) ? 9'sd0 : 9'($urandom);
			hy = ($urandom_range(9) == 0) ? 9'sd0 : 9'($urandom);
			if ($urandom_range(3) == 0) begin
				hx = 9'($signed($urandom_range(6)) - 3);
				hy = 9'($signed($urandom_range(6)) - 3);
			end
			for (int k = 0; k < np; k++)
				send_particle(hx, hy, rand16(), rand16(), rand16(), rand16(),
					k == np - 1, (k == np - 1) && (w == nw - 1));
		end
	endtask

	// extremes of every field, zero wavevector, both projections, clamped sides
	task automatic test_directed();
		send_particle(9'sd1, 9'sd0, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 1'b1, 1'b1);
		send_particle(-9'sd256, 9'sd255, -16'sd32768, 16'sh7FFF, 16'sh7FFF, -16'sd32768,
			1'b0, 1'b0);
		send_particle(-9'sd256, 9'sd255, 16'sh7FFF, -16'sd32768, -16'sd32768, 16'sh7FFF,
			1'b1, 1'b0);
		send_particle(9'sd0, 9'sd0, 16'sh7FFF, 16'sh7FFF, 16'sd100, 16'sd5, 1'b1, 1'b0);
		send_particle(9'sd255, -9'sd256, 16'sd1234, -16'sd4321, 16'sd64, 16'sd32, 1'b0, 1'b1);
		send_particle(9'sd0, 9'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
		write_reg(CFG_TRANS, 9'd1);
		send_particle(9'sd3, -9'sd2, -16'sd32768, -16'sd32768, 16'sd17, -16'sd9, 1'b0, 1'b0);
		send_particle(9'sd3, -9'sd2, 16'sh7FFF, -16'sd32768, -16'sd1, 16'sd1, 1'b1, 1'b1);
		write_reg(CFG_SIDE, 9'd0);
		send_particle(9'sd1, 9'sd1, 16'sh4000, 16'sh4000, 16'sd33, 16'sd7, 1'b1, 1'b1);
		write_reg(CFG_SIDE, 9'd511);
		send_particle(9'sd7, 9'sd5, 16'sh4000, -16'sh4000, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
		write_reg(CFG_SIDE, 9'd256);
		send_particle(9'sd255, 9'sd255, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b0, 1'b1);
		write_reg(CFG_TRANS, 9'd0);
	endtask

	// random sets across sides, projections and idling phases
	task automatic test_random_sets();
		int sent;
		sent = 0;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 46; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 46; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			write_reg(CFG_SIDE, (ph == 3) ? 9'd1 : (ph == 6) ? 9'd256 : 9'($urandom_range(40, 1)));
			write_reg(CFG_TRANS, 9'(ph % 2));
			for (int n = 0; n < 140; n++) begin
				if ($urandom_range(9) == 0) begin
					// loose beat with random close marks
					send_particle(9'($urandom), 9'($urandom), rand16(), rand16(), rand16(),
						rand16(), 1'($urandom), 1'($urandom));
					n++;
				end else begin
					send_random_set(3, 3);
					n += 4;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = CFG_SIDE; cfg_data = '0;
		in_valid = 1'b0; wave_x = '0; wave_y = '0; eigen_x = '0; eigen_y = '0;
		pos_x = '0; pos_y = '0; last_particle = 1'b0; last_wave = 1'b0;
		out_ready = 1'b0;
		pred_side = 9'd16; pred_trans = 1'b0;
		pred_re = 0; pred_im = 0; pred_total = 0; pred_ovf = 1'b0;
		mismatches = 0; cycles = 0; idle_pct = 0; stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_sets();
		in_valid <= 1'b0;
		while (pending_totals.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
